/* hw/rtl/ptft_pkg.sv */
// Package for the peer table: field widths, reset values, codes and shared types.
`timescale 1ns / 1ps
`default_nettype none

package ptft_pkg;

    // Default table depth
    localparam int MAX_PEERS_DEF = 16;

    // Field widths
    localparam int SESSION_W   = 32;
    localparam int IP_W        = 32;
    localparam int PORT_W      = 16;
    localparam int KEY_W       = IP_W + PORT_W;
    localparam int SEQ_W       = 16;
    localparam int AGE_W       = 16;
    localparam int TIMEOUT_W   = 16;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 4;
    localparam int COUNT_OUT_W = 5;
    localparam int EVICT_W     = 5;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;

    // Reset values and constants
    localparam logic [SESSION_W-1:0] SESSION_RST = 32'h9832_5423;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd300;
    localparam logic [SEQ_W-1:0]     SEQ_HALF    = 16'd32768;
    localparam logic [AGE_W-1:0]     AGE_MAX     = 16'hFFFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SESSION_ID = 8'd0,
        CFG_TIMEOUT    = 8'd1
    } t_cfg_idx;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_BAD_SESSION = 3'd0,
        ST_STALE       = 3'd1,
        ST_ACC_KNOWN   = 3'd2,
        ST_ACC_NEW     = 3'd3,
        ST_TABLE_FULL  = 3'd4,
        ST_TICK_DONE   = 3'd5
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_TICK,
        S_LOOK,
        S_PUSH
    } t_state;

    // Table read address source
    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_NEXT,
        RD_LAST
    } t_rd_sel;

    // Table write source
    typedef enum logic [1:0] {
        WR_NONE,
        WR_AGED,
        WR_HIT,
        WR_APPEND
    } t_wr_sel;

    // One table entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [SEQ_W-1:0] seq;
        logic [AGE_W-1:0] age;
    } t_entry;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load;
        t_wr_sel wr_sel;
        t_rd_sel rd_sel;
        logic    idx_inc;
        logic    evict;
        logic    set_res;
        t_status res_status;
        logic    push;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic func;
        logic sess_ok;
        logic idx_lt_count;
        logic key_hit;
        logic newer;
        logic expire;
        logic full;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* hw/rtl/ptft_ctrl.sv */
// Controller state machine for the peer table: sequences lookup, append and ageing walks.
`timescale 1ns / 1ps
`default_nettype none

module ptft_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire ptft_pkg::t_sts i_sts,
    output ptft_pkg::t_cmd     o_cmd
);
    import ptft_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state           = r_state;
        o_cmd             = '0;
        o_cmd.wr_sel      = WR_NONE;
        o_cmd.rd_sel      = RD_IDX;
        o_cmd.res_status  = ST_BAD_SESSION;
        o_in_stall        = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                // capture the item on transfer
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                // read slot 0 and pick the walk
                o_cmd.rd_sel = RD_IDX;
                if (i_sts.func) begin
                    n_state = S_TICK;
                end else if (!i_sts.sess_ok) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_BAD_SESSION;
                    n_state          = S_PUSH;
                end else begin
                    n_state = S_LOOK;
                end
            end
            S_TICK: begin
                if (!i_sts.idx_lt_count) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_TICK_DONE;
                    n_state          = S_PUSH;
                end else if (i_sts.expire) begin
                    // drop this entry, fetch the last one to fill its slot
                    o_cmd.evict  = 1'b1;
                    o_cmd.rd_sel = RD_LAST;
                end else begin
                    // store the aged entry and advance
                    o_cmd.wr_sel  = WR_AGED;
                    o_cmd.idx_inc = 1'b1;
                    o_cmd.rd_sel  = RD_IDX_NEXT;
                end
            end
            S_LOOK: begin
                if (!i_sts.idx_lt_count) begin
                    o_cmd.set_res = 1'b1;
                    if (i_sts.full) begin
                        o_cmd.res_status = ST_TABLE_FULL;
                    end else begin
                        o_cmd.wr_sel     = WR_APPEND;
                        o_cmd.res_status = ST_ACC_NEW;
                    end
                    n_state = S_PUSH;
                end else if (i_sts.key_hit) begin
                    o_cmd.set_res = 1'b1;
                    if (i_sts.newer) begin
                        o_cmd.wr_sel     = WR_HIT;
                        o_cmd.res_status = ST_ACC_KNOWN;
                    end else begin
                        o_cmd.res_status = ST_STALE;
                    end
                    n_state = S_PUSH;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    o_cmd.rd_sel  = RD_IDX_NEXT;
                end
            end
            S_PUSH: begin
                // hand the result to the output register once it is free
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/ptft_dp.sv */
// Datapath for the peer table: entry memory, counters, configuration and output register.
`timescale 1ns / 1ps
`default_nettype none

module ptft_dp #(
    parameter int P_MAX_PEERS = ptft_pkg::MAX_PEERS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire ptft_pkg::t_cmd                   i_cmd,
    output ptft_pkg::t_sts                        o_sts,
    input  wire logic                             i_cfg_wr,
    input  wire logic [ptft_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ptft_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_func,
    input  wire logic [ptft_pkg::SESSION_W-1:0]   i_pkt_session,
    input  wire logic [ptft_pkg::IP_W-1:0]        i_src_ip,
    input  wire logic [ptft_pkg::PORT_W-1:0]      i_src_port,
    input  wire logic [ptft_pkg::SEQ_W-1:0]       i_seq_id,
    input  wire logic                             i_out_stall,
    output logic                                  o_out_valid,
    output logic [ptft_pkg::STATUS_W-1:0]         o_status,
    output logic [ptft_pkg::SLOT_W-1:0]           o_slot,
    output logic [ptft_pkg::COUNT_OUT_W-1:0]      o_peer_count,
    output logic [ptft_pkg::EVICT_W-1:0]          o_evicted
);
    import ptft_pkg::*;

    localparam int IW = (P_MAX_PEERS > 1) ? $clog2(P_MAX_PEERS) : 1;
    localparam int CW = $clog2(P_MAX_PEERS + 1);

    // Captured item
    logic                 r_func;
    logic [SESSION_W-1:0] r_session;
    logic [KEY_W-1:0]     r_key;
    logic [SEQ_W-1:0]     r_seq;

    // Configuration
    logic [SESSION_W-1:0] r_session_id;
    logic [TIMEOUT_W-1:0] r_timeout;

    // Walk state
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_ev;

    // Table
    t_entry r_mem [P_MAX_PEERS];
    t_entry r_rdata;

    // Result and output register
    t_status             r_res_status;
    logic [IW-1:0]       r_res_slot;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [COUNT_OUT_W-1:0] r_out_count;
    logic [EVICT_W-1:0]  r_out_evicted;

    logic [CW-1:0]    w_idx_next;
    logic [CW-1:0]    w_count_dec;
    logic [AGE_W-1:0] w_age_inc;
    logic [SEQ_W-1:0] w_seq_diff;
    logic [IW-1:0]    w_rd_addr;
    logic             w_we;
    logic [IW-1:0]    w_wa;
    t_entry           w_wd;

    assign w_idx_next  = r_idx + CW'(1);
    assign w_count_dec = r_count - CW'(1);

    // Saturating age step and wraparound freshness test
    assign w_age_inc  = (r_rdata.age == AGE_MAX) ? AGE_MAX : r_rdata.age + AGE_W'(1);
    assign w_seq_diff = r_seq - r_rdata.seq;

    // Status to the controller
    always_comb begin
        o_sts.func         = r_func;
        o_sts.sess_ok      = (r_session == r_session_id);
        o_sts.idx_lt_count = (r_idx < r_count);
        o_sts.key_hit      = (r_rdata.key == r_key);
        o_sts.newer        = (w_seq_diff != '0) && (w_seq_diff <= SEQ_HALF);
        o_sts.expire       = (w_age_inc >= r_timeout);
        o_sts.full         = (r_count >= CW'(P_MAX_PEERS));
        o_sts.out_free     = !r_out_valid || !i_out_stall;
    end

    // Read address select
    always_comb begin
        case (i_cmd.rd_sel)
            RD_IDX:      w_rd_addr = r_idx[IW-1:0];
            RD_IDX_NEXT: w_rd_addr = w_idx_next[IW-1:0];
            RD_LAST:     w_rd_addr = w_count_dec[IW-1:0];
            default:     w_rd_addr = r_idx[IW-1:0];
        endcase
    end

    // Write port select
    always_comb begin
        w_we = 1'b1;
        w_wa = r_idx[IW-1:0];
        w_wd = '{key: r_key, seq: r_seq, age: '0};
        case (i_cmd.wr_sel)
            WR_NONE: begin
                w_we = 1'b0;
            end
            WR_AGED: begin
                w_wd = '{key: r_rdata.key, seq: r_rdata.seq, age: w_age_inc};
            end
            WR_HIT: begin
                w_wa = r_idx[IW-1:0];
            end
            WR_APPEND: begin
                w_wa = r_count[IW-1:0];
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    // Capture the item on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= i_func;
            r_session <= i_pkt_session;
            r_key     <= {i_src_ip, i_src_port};
            r_seq     <= i_seq_id;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session_id <= SESSION_RST;
            r_timeout    <= TIMEOUT_RST;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                CFG_SESSION_ID: r_session_id <= i_cfg_data[SESSION_W-1:0];
                CFG_TIMEOUT:    r_timeout    <= i_cfg_data[TIMEOUT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Peer count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.evict) begin
            r_count <= w_count_dec;
        end else if (i_cmd.wr_sel == WR_APPEND) begin
            r_count <= r_count + CW'(1);
        end
    end

    // Walk index and eviction tally
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx <= '0;
            r_ev  <= '0;
        end else begin
            if (i_cmd.idx_inc) begin
                r_idx <= w_idx_next;
            end
            if (i_cmd.evict) begin
                r_ev <= r_ev + CW'(1);
            end
        end
    end

    // Hold the result until the output register is free
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_status;
            case (i_cmd.res_status)
                ST_STALE, ST_ACC_KNOWN: r_res_slot <= r_idx[IW-1:0];
                ST_ACC_NEW:             r_res_slot <= r_count[IW-1:0];
                default:                r_res_slot <= '0;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_status  <= r_res_status;
            r_out_slot    <= SLOT_W'(r_res_slot);
            r_out_count   <= COUNT_OUT_W'(r_count);
            r_out_evicted <= EVICT_W'(r_ev);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_slot       = r_out_slot;
    assign o_peer_count = r_out_count;
    assign o_evicted    = r_out_evicted;

endmodule

`default_nettype wire

/* hw/rtl/peer_table_with_freshness_and_timeout.sv */
// Peer table with freshness check and idle timeout: top level.
//
// Input channel (i_in_valid / o_in_stall) carries one item per transfer:
// a packet (i_func = 0) or an ageing tick (i_func = 1). Every item gives
// exactly one result on the output channel (o_out_valid / i_out_stall).
// Configuration writes (i_cfg_valid / o_cfg_ready) set the session id
// (index 0) and the timeout in ticks (index 1); other indexes are ignored.
// Write configuration only while no item is in flight.
// A packet compares table slots in turn until a hit or the end of the table;
// a tick visits every entry, ageing the survivors and removing expired ones.
// Both walks read the single entry memory once per cycle, so one item is
// worked on at a time; a bad session item skips the walk.
// Reset (synchronous, active low) empties the table and loads the default
// session id and timeout; there is no clearing pass over the memory.
// A stalled result stays in the output register; the next item is still
// accepted, and its result waits internally until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module peer_table_with_freshness_and_timeout #(
    parameter int P_MAX_PEERS = ptft_pkg::MAX_PEERS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // item channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_func,
    input  wire logic [ptft_pkg::SESSION_W-1:0]   i_pkt_session,
    input  wire logic [ptft_pkg::IP_W-1:0]        i_src_ip,
    input  wire logic [ptft_pkg::PORT_W-1:0]      i_src_port,
    input  wire logic [ptft_pkg::SEQ_W-1:0]       i_seq_id,
    // result channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [ptft_pkg::STATUS_W-1:0]         o_status,
    output logic [ptft_pkg::SLOT_W-1:0]           o_slot,
    output logic [ptft_pkg::COUNT_OUT_W-1:0]      o_peer_count,
    output logic [ptft_pkg::EVICT_W-1:0]          o_evicted,
    // configuration channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [ptft_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ptft_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ptft_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Configuration is always taken
    assign o_cfg_ready = 1'b1;

    ptft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ptft_dp #(
        .P_MAX_PEERS (P_MAX_PEERS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_wr      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_func        (i_func),
        .i_pkt_session (i_pkt_session),
        .i_src_ip      (i_src_ip),
        .i_src_port    (i_src_port),
        .i_seq_id      (i_seq_id),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_peer_count  (o_peer_count),
        .o_evicted     (o_evicted)
    );

endmodule

`default_nettype wire

/* bench/ptft_checker.sv */
// Peer table checker: watches the item, result and register channels, predicts and compares.
`timescale 1ns / 1ps

module ptft_checker #(
    parameter int P_MAX_PEERS = ptft_pkg::MAX_PEERS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // item channel
    input  wire logic                             i_in_valid,
    input  wire logic                             i_in_stall,
    input  wire logic                             i_func,
    input  wire logic [ptft_pkg::SESSION_W-1:0]   i_pkt_session,
    input  wire logic [ptft_pkg::IP_W-1:0]        i_src_ip,
    input  wire logic [ptft_pkg::PORT_W-1:0]      i_src_port,
    input  wire logic [ptft_pkg::SEQ_W-1:0]       i_seq_id,
    // result channel
    input  wire logic                             i_out_valid,
    input  wire logic                             i_out_stall,
    input  wire logic [ptft_pkg::STATUS_W-1:0]    i_status,
    input  wire logic [ptft_pkg::SLOT_W-1:0]      i_slot,
    input  wire logic [ptft_pkg::COUNT_OUT_W-1:0] i_peer_count,
    input  wire logic [ptft_pkg::EVICT_W-1:0]     i_evicted,
    // register channel
    input  wire logic                             i_cfg_valid,
    input  wire logic                             i_cfg_ready,
    input  wire logic [ptft_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ptft_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // to the bench top
    output int                                    o_errors,
    output int                                    o_pending
);

    import ptft_pkg::*;

    typedef struct packed {
        t_status                status;
        logic [SLOT_W-1:0]      slot;
        logic [COUNT_OUT_W-1:0] peer_count;
        logic [EVICT_W-1:0]     evicted;
    } t_outcome;

    // Shadow copy of the peer table and the registers
    logic [KEY_W-1:0]     tab_key [P_MAX_PEERS];
    logic [SEQ_W-1:0]     tab_seq [P_MAX_PEERS];
    logic [AGE_W-1:0]     tab_age [P_MAX_PEERS];
    int unsigned          n_peers = 0;
    logic [SESSION_W-1:0] cur_session = SESSION_RST;
    logic [TIMEOUT_W-1:0] cur_timeout = TIMEOUT_RST;

    t_outcome outcomes_due [$];
    int       fails = 0;

    function automatic t_outcome make_outcome(t_status st, int unsigned sl, int unsigned gone);
        t_outcome r;
        r.status     = st;
        r.slot       = SLOT_W'(sl);
        r.peer_count = COUNT_OUT_W'(n_peers);
        r.evicted    = EVICT_W'(gone);
        return r;
    endfunction

    // Age every entry; an expired entry is replaced by the last one, which is then checked too
    function automatic t_outcome age_peers();
        int unsigned i;
        int unsigned gone;
        int unsigned last;
        i    = 0;
        gone = 0;
        while (i < n_peers) begin
            if (tab_age[i] != AGE_MAX)
                tab_age[i] = tab_age[i] + 1'b1;
            if (tab_age[i] >= cur_timeout) begin
                last       = n_peers - 1;
                tab_key[i] = tab_key[last];
                tab_seq[i] = tab_seq[last];
                tab_age[i] = tab_age[last];
                n_peers    = last;
                gone++;
            end else begin
                i++;
            end
        end
        return make_outcome(ST_TICK_DONE, 0, gone);
    endfunction

    // Session filter, lookup, freshness test and append
    function automatic t_outcome admit_packet(logic [SESSION_W-1:0] sess, logic [IP_W-1:0] ip,
                                              logic [PORT_W-1:0] port, logic [SEQ_W-1:0] seq);
        logic [KEY_W-1:0] key;
        logic [SEQ_W-1:0] ahead;
        int unsigned      i;
        int unsigned      sl;
        if (sess != cur_session)
            return make_outcome(ST_BAD_SESSION, 0, 0);
        key = {ip, port};
        for (i = 0; i < n_peers; i++) begin
            if (tab_key[i] == key) begin
                ahead = seq - tab_seq[i];
                if (ahead != '0 && ahead <= SEQ_HALF) begin
                    tab_seq[i] = seq;
                    tab_age[i] = '0;
                    return make_outcome(ST_ACC_KNOWN, i, 0);
                end
                return make_outcome(ST_STALE, i, 0);
            end
        end
        if (n_peers >= P_MAX_PEERS)
            return make_outcome(ST_TABLE_FULL, 0, 0);
        sl          = n_peers;
        tab_key[sl] = key;
        tab_seq[sl] = seq;
        tab_age[sl] = '0;
        n_peers++;
        return make_outcome(ST_ACC_NEW, sl, 0);
    endfunction

    task automatic check_field(input string what, input int unsigned want, input int unsigned got);
        if (want != got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // Track register writes, compare results, predict accepted items
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            n_peers     = 0;
            cur_session = SESSION_RST;
            cur_timeout = TIMEOUT_RST;
            outcomes_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SESSION_ID: cur_session = i_cfg_data[SESSION_W-1:0];
                    CFG_TIMEOUT:    cur_timeout = i_cfg_data[TIMEOUT_W-1:0];
                    default: ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                if (outcomes_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, i_status);
                end else begin
                    want = outcomes_due.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("slot", want.slot, i_slot);
                    check_field("peer_count", want.peer_count, i_peer_count);
                    check_field("evicted", want.evicted, i_evicted);
                end
            end

            // func high marks a tick
            if (i_in_valid && !i_in_stall) begin
                if (i_func)
                    outcomes_due.push_back(age_peers());
                else
                    outcomes_due.push_back(admit_packet(i_pkt_session, i_src_ip, i_src_port,
                                                        i_seq_id));
            end
        end
        o_pending <= outcomes_due.size();
        o_errors  <= fails;
    end

endmodule

/* bench/testbench.sv */
// Bench top for the peer table: clock, reset, stimulus, stall pattern and verdict.
`timescale 1ns / 1ps

module testbench;

    import ptft_pkg::*;

    localparam logic FUNC_PACKET = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd7;

    localparam int POOL_N         = 24;
    localparam int SETTLE_CYCLES  = MAX_PEERS_DEF + 8;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid    = 1'b0;
    logic                   func        = FUNC_PACKET;
    logic [SESSION_W-1:0]   pkt_session = '0;
    logic [IP_W-1:0]        src_ip      = '0;
    logic [PORT_W-1:0]      src_port    = '0;
    logic [SEQ_W-1:0]       seq_id      = '0;
    logic                   out_stall   = 1'b0;
    logic                   cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;

    logic                   in_stall;
    logic                   out_valid;
    logic [STATUS_W-1:0]    status;
    logic [SLOT_W-1:0]      slot;
    logic [COUNT_OUT_W-1:0] peer_count;
    logic [EVICT_W-1:0]     evicted;
    logic                   cfg_ready;

    int errors;
    int pending;

    // Peer pool the random part draws from, with the last fresh sequence number sent to each
    logic [IP_W-1:0]      pool_ip   [POOL_N];
    logic [PORT_W-1:0]    pool_port [POOL_N];
    logic [SEQ_W-1:0]     pool_seq  [POOL_N];
    logic [SESSION_W-1:0] session_now = SESSION_RST;

    int burst_left  = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    int stall_mode  = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    peer_table_with_freshness_and_timeout dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_func        (func),
        .i_pkt_session (pkt_session),
        .i_src_ip      (src_ip),
        .i_src_port    (src_port),
        .i_seq_id      (seq_id),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (status),
        .o_slot        (slot),
        .o_peer_count  (peer_count),
        .o_evicted     (evicted),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    ptft_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_func        (func),
        .i_pkt_session (pkt_session),
        .i_src_ip      (src_ip),
        .i_src_port    (src_port),
        .i_seq_id      (seq_id),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_status      (status),
        .i_slot        (slot),
        .i_peer_count  (peer_count),
        .i_evicted     (evicted),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    // Result stall: switch between free running, coin flips, a fixed pattern and heavy stall
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) == 1);
            2:       out_stall <= ((stall_left % 7) < 3);
            default: out_stall <= ($urandom_range(0, 15) < 13);
        endcase
    end

    // End the run if nothing moves on any channel for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one item and hold it until the transfer; open a gap between bursts
    task automatic send_item(input logic f, input logic [SESSION_W-1:0] sess,
                             input logic [IP_W-1:0] ip, input logic [PORT_W-1:0] port,
                             input logic [SEQ_W-1:0] seq);
        int gap;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        in_valid    <= 1'b1;
        func        <= f;
        pkt_session <= sess;
        src_ip      <= ip;
        src_port    <= port;
        seq_id      <= seq;
        do @(posedge clk); while (in_stall);
        burst_left--;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, wait for every result, then let the block settle
    task automatic wait_idle();
        in_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly fresh packets from known peers, with stale, borderline, foreign and tick items mixed in
    task automatic random_item(input int active_n, input int tick_pct);
        int                   p;
        int                   pick;
        logic [SEQ_W-1:0]     seq;
        logic [SESSION_W-1:0] sess;
        if ($urandom_range(0, 99) < tick_pct) begin
            send_item(FUNC_TICK, $urandom, $urandom, $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
        end else begin
            p = $urandom_range(0, active_n - 1);
            if ($urandom_range(0, 31) == 0) begin
                pool_ip[p]   = $urandom;
                pool_port[p] = $urandom_range(0, 65535);
            end
            sess = session_now;
            if ($urandom_range(0, 19) == 0)
                sess = ($urandom_range(0, 1) == 1) ? $urandom
                                                   : session_now ^ (32'd1 << $urandom_range(0, 31));
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                seq         = pool_seq[p] + 16'($urandom_range(1, 200));
                pool_seq[p] = seq;
            end else if (pick < 65) begin
                seq = pool_seq[p];
            end else if (pick < 75) begin
                seq = pool_seq[p] - 16'($urandom_range(1, 200));
            end else if (pick < 80) begin
                seq         = pool_seq[p] + SEQ_HALF;
                pool_seq[p] = seq;
            end else if (pick < 85) begin
                seq = pool_seq[p] + SEQ_HALF + 1'b1;
            end else begin
                seq = $urandom_range(0, 65535);
            end
            send_item(FUNC_PACKET, sess, pool_ip[p], pool_port[p], seq);
        end
    endtask

    task automatic run_phase(input logic [SESSION_W-1:0] sess, input logic [TIMEOUT_W-1:0] tmo,
                             input int n_items, input int active_n, input int tick_pct);
        wait_idle();
        write_reg(CFG_SESSION_ID, sess);
        write_reg(CFG_TIMEOUT, {16'($urandom), tmo});
        write_reg(CFG_UNUSED, $urandom);
        session_now = sess;
        repeat (n_items) random_item(active_n, tick_pct);
    endtask

    initial begin
        int k;
        for (k = 0; k < POOL_N; k++) begin
            pool_ip[k]   = $urandom;
            pool_port[k] = $urandom_range(0, 65535);
            pool_seq[k]  = $urandom_range(0, 65535);
        end
        pool_ip[0]   = '0;
        pool_port[0] = '0;
        pool_seq[0]  = '0;
        pool_ip[1]   = '1;
        pool_port[1] = '1;
        pool_seq[1]  = '1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: foreign session, tick on an empty table, freshness edges, fill to full
        send_item(FUNC_PACKET, SESSION_RST ^ 32'h1, '0, '0, '0);
        send_item(FUNC_TICK, '0, '0, '0, '0);
        send_item(FUNC_PACKET, SESSION_RST, '0, '0, 16'h0000);
        send_item(FUNC_PACKET, SESSION_RST, '0, '0, 16'h0000);
        send_item(FUNC_PACKET, SESSION_RST, '0, '0, SEQ_HALF);
        send_item(FUNC_PACKET, SESSION_RST, '0, '0, 16'h0001);
        send_item(FUNC_PACKET, SESSION_RST, '0, '0, 16'hFFFF);
        send_item(FUNC_PACKET, SESSION_RST, '0, '0, 16'h0000);
        send_item(FUNC_PACKET, SESSION_RST, '1, '1, 16'hFFFF);
        for (k = 2; k < MAX_PEERS_DEF; k++)
            send_item(FUNC_PACKET, SESSION_RST, pool_ip[k], pool_port[k], pool_seq[k]);
        send_item(FUNC_PACKET, SESSION_RST, pool_ip[MAX_PEERS_DEF], pool_port[MAX_PEERS_DEF],
                  pool_seq[MAX_PEERS_DEF]);
        send_item(FUNC_TICK, '1, '1, '1, '1);

        // Random phases across register settings, extremes included
        run_phase(SESSION_RST, TIMEOUT_RST, 250, 20, 10);
        run_phase($urandom, 16'd1, 200, 12, 20);
        run_phase('0, 16'd4, 250, 20, 25);
        run_phase('1, 16'hFFFF, 200, POOL_N, 10);
        run_phase($urandom, 16'd0, 150, 10, 15);
        run_phase($urandom, 16'($urandom_range(2, 12)), 250, 18, 20);
        run_phase(SESSION_RST, TIMEOUT_RST, 150, 16, 5);

        wait_idle();
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
